@@ hw/rtl/ilst_pkg.sv @@
package ilst_pkg;

    localparam int DEFAULT_CAPACITY = 256;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 9;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_in;
    } ilst_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic [COUNT_W-1:0]       element_count;
    } ilst_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic get_read;
        logic move_start;
        logic move_read;
        logic place;
        logic commit;
    } ilst_ctl_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_get;
        logic is_insert;
        logic ok;
        logic no_moves;
        logic move_last;
        logic out_free;
    } ilst_stat_t;

endpackage

@@ hw/rtl/ilst_datapath.sv @@
module ilst_datapath
    import ilst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ilst_cmd_t  cmd,
    input  ilst_ctl_t  ctl,
    output ilst_stat_t stat,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output ilst_rsp_t  rsp
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_W-1:0] mem [CAPACITY];

    ilst_cmd_t         cmd_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     src_reg;
    logic [AW-1:0]     end_reg;
    logic              up_reg;
    logic              wvalid_reg;
    logic [AW-1:0]     wdst_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    ilst_rsp_t         rsp_reg;
    ilst_rsp_t         rsp_next;

    logic [CMPW-1:0] count_x;
    logic [CMPW-1:0] pos_eff;
    logic            is_get;
    logic            is_insert;
    logic            is_delete;
    logic            range_err;
    logic            full_err;
    logic            ok;
    logic [AW-1:0]   pos_addr;
    logic [AW-1:0]   last_addr;
    logic [AW-1:0]   rd_addr;

    always_comb
    begin
        count_x = CMPW'(count_reg);
        case (cmd_reg.command)
            CMD_INS_HEAD: pos_eff = '0;
            CMD_INS_TAIL: pos_eff = count_x;
            default:      pos_eff = CMPW'(cmd_reg.position);
        endcase
        is_get    = (cmd_reg.command == CMD_GET);
        is_insert = (cmd_reg.command inside {CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT});
        is_delete = (cmd_reg.command == CMD_DELETE);
        if (is_get || is_delete)
            range_err = (pos_eff >= count_x);
        else if (is_insert)
            range_err = (pos_eff > count_x);
        else
            range_err = 1'b1;
        full_err  = is_insert && !range_err && (count_x == CMPW'(CAPACITY));
        ok        = !range_err && !full_err;
        pos_addr  = pos_eff[AW-1:0];
        last_addr = AW'(count_reg - 1'b1);
        rd_addr   = ctl.move_read ? src_reg : pos_addr;
    end

    always_comb
    begin
        stat.is_get    = is_get;
        stat.is_insert = is_insert;
        stat.ok        = ok;
        if (is_insert)
            stat.no_moves = (pos_eff == count_x);
        else
            stat.no_moves = ((pos_eff + CMPW'(1)) == count_x);
        stat.move_last = (src_reg == end_reg);
        stat.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    // Element store: one write port and one registered read port. A move reads
    // a slot in one cycle and writes it to its neighbor in the next.
    always_ff @(posedge clk)
    begin
        if (wvalid_reg)
            mem[wdst_reg] <= rd_data_reg;
        else if (ctl.place)
            mem[pos_addr] <= cmd_reg.data_in;
        if (ctl.move_read || ctl.get_read)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
            cmd_reg <= cmd;
        if (ctl.move_start)
        begin
            src_reg <= is_insert ? last_addr : AW'(pos_addr + 1'b1);
            end_reg <= is_insert ? pos_addr : last_addr;
            up_reg  <= is_insert;
        end
        else if (ctl.move_read)
        begin
            src_reg <= up_reg ? AW'(src_reg - 1'b1) : AW'(src_reg + 1'b1);
        end
        if (ctl.move_read)
            wdst_reg <= up_reg ? AW'(src_reg + 1'b1) : AW'(src_reg - 1'b1);
        if (ctl.commit)
            rsp_reg <= rsp_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ok && is_insert)
            count_next = CW'(count_reg + 1'b1);
        else if (ok && is_delete)
            count_next = CW'(count_reg - 1'b1);

        if (full_err)
            rsp_next.status = ST_FULL;
        else if (range_err)
            rsp_next.status = ST_RANGE;
        else
            rsp_next.status = ST_DONE;
        if (is_get)
            rsp_next.read_value = range_err ? '1 : rd_data_reg;
        else
            rsp_next.read_value = '0;
        rsp_next.element_count = COUNT_W'(count_next);

        if (ctl.commit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
                count_reg <= count_next;
            wvalid_reg    <= ctl.move_read;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hw/rtl/ilst_ctrl.sv @@
module ilst_ctrl
    import ilst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  ilst_stat_t stat,
    output ilst_ctl_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MOVE,
        S_DRAIN,
        S_PLACE,
        S_GET_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   cmd_stall_reg;
    logic   cmd_stall_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.ok)
                begin
                    if (stat.out_free)
                    begin
                        ctl.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.is_get)
                begin
                    ctl.get_read = 1'b1;
                    state_next   = S_GET_WAIT;
                end
                else if (stat.no_moves)
                begin
                    if (stat.is_insert)
                        state_next = S_PLACE;
                    else if (stat.out_free)
                    begin
                        ctl.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.move_start = 1'b1;
                    state_next     = S_MOVE;
                end
            end
            S_MOVE:
            begin
                ctl.move_read = 1'b1;
                if (stat.move_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // The last move's write lands in this cycle.
                if (stat.is_insert)
                    state_next = S_PLACE;
                else if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PLACE:
            begin
                ctl.place = 1'b1;
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_GET_WAIT:
            begin
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd_stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_stall_reg <= cmd_stall_next;
        end
    end

    assign cmd_stall = cmd_stall_reg;

endmodule

@@ hw/rtl/indexed_list_store.sv @@
// Bounded ordered list of signed 32-bit values, CAPACITY elements deep.
// Command channel (cmd_valid, cmd_stall, cmd): a transfer carries a command
// (get, insert at head, at tail, before a position, or delete), a position
// and a value. Response channel (rsp_valid, rsp_stall, rsp): each command
// gives exactly one response with the read value, a status and the element
// count after the command.
// Commands are handled one at a time. After the check, a rejected command is
// answered from the check state, a get waits for its memory read, and an insert
// or delete first moves n elements by one slot to open or close the gap at its
// position; an insert then writes its value. The moves go through the element
// memory at one element per cycle, so n is up to CAPACITY - 1. The next
// command is taken in the cycle after its predecessor's response is loaded.
// The response sits in an output register; while the receiver stalls it the
// next command can still be taken and worked on up to its own response.
// Reset empties the list; the element memory itself is not cleared and needs
// no clearing pass, and commands are taken right after reset.
module indexed_list_store
    import ilst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  ilst_cmd_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output ilst_rsp_t rsp
);

    ilst_ctl_t  ctl;
    ilst_stat_t stat;

    ilst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    ilst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
